FILE: rtl/core/upf_pkg.sv
// Shared types and constants for the PNG scanline unfilter core.
// Holds the request/result payload structs, filter kind codes and register indexes.
// No dependencies.
package upf_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int COL_W = $clog2(MAX_ROW_BYTES);
  localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int BPP_W = 4;
  localparam int HIDX_W = $clog2(MAX_PIXEL_BYTES);
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = POS_W;

  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 1'b1;

  localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
  localparam logic [POS_W-1:0] ROW_BYTES_RESET = 14'd4;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_SUB     = 3'd1,
    KIND_UP      = 3'd2,
    KIND_AVERAGE = 3'd3,
    KIND_PAETH   = 3'd4,
    KIND_UNKNOWN = 3'd7
  } upf_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } upf_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } upf_result_t;

endpackage

FILE: rtl/core/png_scanline_unfilter_core.sv
// PNG scanline unfilter: rebuilds None, Sub, Up, Average and Paeth filtered rows.
// A data byte request is registered in stage 1 when taken, then moves to the result register.
// Throughput: one request per cycle unless stalled; prior-row bytes are read as requests are taken.
// Filter type bytes produce no result. Reset is synchronous and clears control state;
// the line buffer is not cleared; on the first row of an image its bytes are not used.
// Depends on upf_pkg.
module png_scanline_unfilter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  upf_pkg::upf_item_t               item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output upf_pkg::upf_result_t             result,
  input  logic                             cfg_we,
  input  logic [upf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [upf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import upf_pkg::*;

  // Configuration registers
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [POS_W-1:0] row_bytes;

  // Row tracking
  logic [POS_W-1:0] row_position;
  logic             first_row;
  upf_kind_t        filter_kind;
  logic             clear_pending;

  // Stage 1 (input register)
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic [COL_W-1:0]  s1_col;
  logic              s1_last;
  logic              s1_first;
  logic              s1_clear;
  upf_kind_t         s1_kind;
  logic [HIDX_W-1:0] s1_bpp_idx;
  logic [7:0]        rd_data;

  logic [7:0] prior_row [MAX_ROW_BYTES];
  logic [7:0] left_hist [MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist [MAX_PIXEL_BYTES];

  logic              acc;
  logic              s1_adv;
  logic [BPP_W-1:0]  bpp_eff;
  logic [HIDX_W-1:0] bpp_idx;
  logic [POS_W-1:0]  rlen_eff;
  logic [POS_W-1:0]  pos_eff;
  logic              is_filter;
  logic [POS_W-1:0]  col_raw;
  logic [POS_W-1:0]  col_full;
  logic              row_last;
  logic              first_eff;
  upf_kind_t         kind_dec;

  logic [7:0] eff_left [MAX_PIXEL_BYTES];
  logic [7:0] eff_upleft [MAX_PIXEL_BYTES];
  logic [7:0] a_val;
  logic [7:0] b_val;
  logic [7:0] c_val;
  logic [7:0] pred;
  logic [7:0] val;
  logic       bad;
  logic [8:0] avg_sum;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] sel;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if (pa <= pb && pa <= pc) begin
      sel = a;
    end else if (pb <= pc) begin
      sel = b;
    end else begin
      sel = c;
    end
    return sel;
  endfunction

  // Stage 1 moves on when the result register is free or being emptied.
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign acc        = item_valid && !item_stall;

  // Request decode against the current row state.
  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
    bpp_idx = HIDX_W'(bpp_eff - BPP_W'(1));

    if (row_bytes == '0) begin
      rlen_eff = POS_W'(1);
    end else if (row_bytes > POS_W'(MAX_ROW_BYTES)) begin
      rlen_eff = POS_W'(MAX_ROW_BYTES);
    end else begin
      rlen_eff = row_bytes;
    end

    pos_eff   = item.image_start ? '0 : row_position;
    first_eff = item.image_start || first_row;
    is_filter = (pos_eff == '0);
    col_raw   = pos_eff - POS_W'(1);
    col_full  = (col_raw >= rlen_eff) ? rlen_eff - POS_W'(1) : col_raw;
    row_last  = (col_full + POS_W'(1)) >= rlen_eff;
    kind_dec  = (item.data_byte <= 8'd4) ? upf_kind_t'(item.data_byte[2:0]) : KIND_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
      row_bytes       <= ROW_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_ROW_BYTES:       row_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position  <= '0;
      first_row     <= 1'b1;
      filter_kind   <= KIND_NONE;
      clear_pending <= 1'b1;
      s1_valid      <= 1'b0;
    end else begin
      if (acc) begin
        if (is_filter) begin
          filter_kind   <= kind_dec;
          row_position  <= POS_W'(1);
          first_row     <= first_eff;
          clear_pending <= 1'b1;
        end else begin
          row_position  <= row_last ? '0 : col_full + POS_W'(2);
          first_row     <= row_last ? 1'b0 : first_eff;
          clear_pending <= 1'b0;
        end
      end
      if (acc && !is_filter) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !is_filter) begin
      s1_byte    <= item.data_byte;
      s1_col     <= col_full[COL_W-1:0];
      s1_last    <= row_last;
      s1_first   <= first_eff;
      s1_clear   <= clear_pending;
      s1_kind    <= filter_kind;
      s1_bpp_idx <= bpp_idx;
    end
  end

  // Line buffer: read as each data byte request is taken, ahead of use in stage 1, written as each byte retires.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prior_row[s1_col] <= val;
    end
    if (acc && !is_filter) begin
      rd_data <= prior_row[col_full[COL_W-1:0]];
    end
  end

  // Stage 1 reconstruction. The first byte of a row sees cleared histories.
  always_comb begin
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      eff_left[i]   = s1_clear ? 8'd0 : left_hist[i];
      eff_upleft[i] = s1_clear ? 8'd0 : upleft_hist[i];
    end
    a_val   = eff_left[s1_bpp_idx];
    c_val   = eff_upleft[s1_bpp_idx];
    b_val   = s1_first ? 8'd0 : rd_data;
    avg_sum = {1'b0, a_val} + {1'b0, b_val};
    bad     = 1'b0;
    case (s1_kind)
      KIND_NONE:    pred = 8'd0;
      KIND_SUB:     pred = a_val;
      KIND_UP:      pred = b_val;
      KIND_AVERAGE: pred = avg_sum[8:1];
      KIND_PAETH:   pred = paeth(a_val, b_val, c_val);
      default: begin
        pred = 8'd0;
        bad  = 1'b1;
      end
    endcase
    val = s1_byte + pred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= 8'd0;
        upleft_hist[i] <= 8'd0;
      end
    end else if (s1_adv) begin
      left_hist[0]   <= val;
      upleft_hist[0] <= b_val;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= eff_left[i-1];
        upleft_hist[i] <= eff_upleft[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.pixel_byte <= val;
      result.row_end    <= s1_last;
      result.bad_filter <= bad;
    end
  end

endmodule

FILE: rtl/core/upf_checker.sv
// Port-level checker for the PNG scanline unfilter core, bound to the core.
// Depends on upf_pkg and png_scanline_unfilter_core.
module upf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input upf_pkg::upf_result_t             result
);
  import upf_pkg::*;

  // A held result must stay in place until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The core only pushes back when its own result is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("request stalled without a blocked result");

  // A new result needs a request taken earlier, registered in stage 1 and then in the result register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
    else $error("result appeared without a request");

endmodule

bind png_scanline_unfilter_core upf_checker u_upf_checker (.*);
